// ===== src/hcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcmc_pkg
// Shared types and constants for the HSV color mask centroid block.
// ----------------------------------------------------------------------------
package hcmc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 8;
    localparam int CENT_W     = 16;
    localparam int AREA_OUT_W = 25;

    localparam int PIX_NUM_W  = 17;
    localparam int PIX_DEN_W  = 9;
    localparam int PIX_Q_W    = 8;
    localparam int CEN_STEPS  = CENT_W;
    localparam int STEP_CNT_W = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_HUE_LOW_A  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HUE_HIGH_A = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HUE_LOW_B  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HUE_HIGH_B = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAT_MIN    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VAL_MIN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_IMG_WIDTH  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_ACC,
        S_CLOAD,
        S_CDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic acc;
        logic cdiv_load;
        logic cdiv_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

// ===== src/hsv_color_mask_centroid_top.sv =====
// Order per pixel: accept, prep, 8 hue/saturation divider steps, accumulate,
// result register. A pixel with frame_end adds the centroid divider load and
// 16 steps before the result register. No new pixel is taken (o_stall high)
// until the last one is through. A stalled result holds off the next one.
// Reset: synchronous active-low; config returns to defaults, sums clear.
// ----------------------------------------------------------------------------
// hsv_color_mask_centroid_top
// BGR to HSV threshold mask with running blob area and centroid.
// ----------------------------------------------------------------------------
module hsv_color_mask_centroid_top
    import hcmc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAN_W-1:0]     i_blue_value,
    input  logic [CHAN_W-1:0]     i_green_value,
    input  logic [CHAN_W-1:0]     i_red_value,
    input  logic                  i_frame_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_in_mask,
    output logic                  o_frame_done,
    output logic                  o_object_found,
    output logic [CENT_W-1:0]     o_centroid_x,
    output logic [CENT_W-1:0]     o_centroid_y,
    output logic [AREA_OUT_W-1:0] o_mask_area
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    hcmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hcmc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_blue_value   (i_blue_value),
        .i_green_value  (i_green_value),
        .i_red_value    (i_red_value),
        .i_frame_end    (i_frame_end),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_in_mask      (o_in_mask),
        .o_frame_done   (o_frame_done),
        .o_object_found (o_object_found),
        .o_centroid_x   (o_centroid_x),
        .o_centroid_y   (o_centroid_y),
        .o_mask_area    (o_mask_area)
    );

endmodule

// ===== src/hcmc_div.sv =====
// ----------------------------------------------------------------------------
// hcmc_div
// Restoring divider, one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module hcmc_div #(
    parameter int NW = 17,
    parameter int DW = 9,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [NW-1:0] i_numer,
    input  logic [DW-1:0] i_denom,
    output logic [QW-1:0] o_quot
);

    localparam int IW = DW + QW;

    logic [IW-1:0] r_rem;
    logic [IW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic          ge;

    assign ge = r_rem >= r_den;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= IW'(i_numer);
            r_den  <= IW'(i_denom) << (QW - 1);
            r_quot <= '0;
        end else if (i_step) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== src/hcmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcmc_ctrl
// Sequencer: pixel conversion, accumulation, frame-end centroid divide and
// output register handshake.
// ----------------------------------------------------------------------------
module hcmc_ctrl
    import hcmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(PIX_Q_W - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last ? S_CLOAD : S_OUT;
            end
            S_CLOAD: begin
                o_cmd.cdiv_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.cdiv_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(CEN_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;

endmodule

// ===== src/hcmc_datapath.sv =====
// ----------------------------------------------------------------------------
// hcmc_datapath
// Config registers, HSV conversion, mask test, position counters, sums,
// centroid dividers and result registers.
// ----------------------------------------------------------------------------
module hcmc_datapath
    import hcmc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CHAN_W-1:0]     i_blue_value,
    input  logic [CHAN_W-1:0]     i_green_value,
    input  logic [CHAN_W-1:0]     i_red_value,
    input  logic                  i_frame_end,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_in_mask,
    output logic                  o_frame_done,
    output logic                  o_object_found,
    output logic [CENT_W-1:0]     o_centroid_x,
    output logic [CENT_W-1:0]     o_centroid_y,
    output logic [AREA_OUT_W-1:0] o_mask_area
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int AREA_LIMIT = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(AREA_LIMIT) + 1;
    localparam int XW         = CW + AW - 1;
    localparam int YW         = RW + AW - 1;

    // config
    logic [CHAN_W-1:0]     r_hue_low_a, r_hue_high_a, r_hue_low_b, r_hue_high_b;
    logic [CHAN_W-1:0]     r_sat_min, r_val_min;
    logic [CFG_DATA_W-1:0] r_img_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low_a  <= 8'd0;
            r_hue_high_a <= 8'd30;
            r_hue_low_b  <= 8'd150;
            r_hue_high_b <= 8'd179;
            r_sat_min    <= 8'd127;
            r_val_min    <= 8'd0;
            r_img_width  <= 13'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HUE_LOW_A:  r_hue_low_a  <= i_cfg_data[CHAN_W-1:0];
                REG_HUE_HIGH_A: r_hue_high_a <= i_cfg_data[CHAN_W-1:0];
                REG_HUE_LOW_B:  r_hue_low_b  <= i_cfg_data[CHAN_W-1:0];
                REG_HUE_HIGH_B: r_hue_high_b <= i_cfg_data[CHAN_W-1:0];
                REG_SAT_MIN:    r_sat_min    <= i_cfg_data[CHAN_W-1:0];
                REG_VAL_MIN:    r_val_min    <= i_cfg_data[CHAN_W-1:0];
                REG_IMG_WIDTH:  r_img_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel capture
    logic [CHAN_W-1:0] r_b, r_g, r_r;
    logic              r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_b    <= i_blue_value;
            r_g    <= i_green_value;
            r_r    <= i_red_value;
            r_last <= i_frame_end;
        end
    end

    assign o_status.last = r_last;

    // max, min, hue and saturation dividends
    logic [CHAN_W-1:0]    mx, mn, diff;
    logic signed [17:0]   sr, sg, sb, sd, h6, num;
    logic [PIX_NUM_W-1:0] hue_numer, sat_numer;
    logic [PIX_DEN_W-1:0] hue_denom, sat_denom;

    always_comb begin
        mx = r_r;
        mn = r_r;
        if (r_g > mx) mx = r_g;
        if (r_b > mx) mx = r_b;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        diff = mx - mn;
        sr = 18'(r_r);
        sg = 18'(r_g);
        sb = 18'(r_b);
        sd = 18'(diff);
        if (mx == r_r) begin
            h6 = sg - sb;
        end else if (mx == r_g) begin
            h6 = sb - sr + 18'sd2 * sd;
        end else begin
            h6 = sr - sg + 18'sd4 * sd;
        end
        num = 18'(h6 * 18'sd30);
        if (num < 0) begin
            num = num + 18'(18'sd180 * sd);
        end
        hue_numer = PIX_NUM_W'(18'(num * 18'sd2) + sd);
        hue_denom = {diff, 1'b0};
        sat_numer = PIX_NUM_W'(17'd510 * 17'(diff) + 17'(mx));
        sat_denom = {mx, 1'b0};
    end

    logic [CHAN_W-1:0] r_mx, r_diff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_mx   <= mx;
            r_diff <= diff;
        end
    end

    logic [PIX_Q_W-1:0] hue_q, sat_q;

    hcmc_div #(.NW(PIX_NUM_W), .DW(PIX_DEN_W), .QW(PIX_Q_W)) u_hue_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.prep),
        .i_step  (i_cmd.div_step),
        .i_numer (hue_numer),
        .i_denom (hue_denom),
        .o_quot  (hue_q)
    );

    hcmc_div #(.NW(PIX_NUM_W), .DW(PIX_DEN_W), .QW(PIX_Q_W)) u_sat_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.prep),
        .i_step  (i_cmd.div_step),
        .i_numer (sat_numer),
        .i_denom (sat_denom),
        .o_quot  (sat_q)
    );

    // mask test
    logic [CHAN_W-1:0] hue, sat;
    logic              band_a, band_b, hit;

    always_comb begin
        if (r_diff == '0) begin
            hue = '0;
        end else if (hue_q >= 8'd180) begin
            hue = hue_q - 8'd180;
        end else begin
            hue = hue_q;
        end
        sat    = (r_mx == '0) ? '0 : sat_q;
        band_a = hue >= r_hue_low_a && hue <= r_hue_high_a;
        band_b = hue >= r_hue_low_b && hue <= r_hue_high_b;
        hit    = sat >= r_sat_min && r_mx >= r_val_min && (band_a || band_b);
    end

    // position and sums
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [AW-1:0]         r_area;
    logic [XW-1:0]         r_xs;
    logic [YW-1:0]         r_ys;
    logic                  r_hit;
    logic [CFG_DATA_W-1:0] w_eff;
    logic                  col_wrap, row_wrap, count_en;

    always_comb begin
        if (r_img_width == '0 || r_img_width > CFG_DATA_W'(MAX_WIDTH)) begin
            w_eff = CFG_DATA_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_width;
        end
        col_wrap = (14'(r_col) + 14'd1) >= 14'(w_eff);
        row_wrap = (14'(r_row) + 14'd1) >= 14'(MAX_HEIGHT);
        count_en = hit && (r_area < AW'(AREA_LIMIT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_area <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
        end else if (i_cmd.acc) begin
            if (count_en) begin
                r_area <= r_area + 1'b1;
                r_xs   <= r_xs + XW'(r_col);
                r_ys   <= r_ys + YW'(r_row);
            end
            if (!r_last) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end else if (i_cmd.out_load && r_last) begin
            r_col  <= '0;
            r_row  <= '0;
            r_area <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_hit <= hit;
        end
    end

    // centroid
    logic [CENT_W-1:0] cx_q, cy_q;

    hcmc_div #(.NW(XW + 4), .DW(AW), .QW(CENT_W)) u_cx_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.cdiv_load),
        .i_step  (i_cmd.cdiv_step),
        .i_numer ({r_xs, 4'b0000}),
        .i_denom (r_area),
        .o_quot  (cx_q)
    );

    hcmc_div #(.NW(YW + 4), .DW(AW), .QW(CENT_W)) u_cy_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.cdiv_load),
        .i_step  (i_cmd.cdiv_step),
        .i_numer ({r_ys, 4'b0000}),
        .i_denom (r_area),
        .o_quot  (cy_q)
    );

    // result register
    logic found;
    assign found = r_last && (r_area != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_in_mask      <= r_hit;
            o_frame_done   <= r_last;
            o_object_found <= found;
            o_centroid_x   <= found ? cx_q : '0;
            o_centroid_y   <= found ? cy_q : '0;
            o_mask_area    <= found ? AREA_OUT_W'(r_area) : '0;
        end
    end

endmodule
